>>> rtl/aat_pkg.sv
// Shared constants, types and the arctangent table of the averaged tilt-angle block.
// Used by aat_tilt and by the top level averaged_accel_tilt_angles.
// Has no dependencies of its own.
package aat_pkg;

  // Field widths and the default ring depth.
  localparam int DATA_W     = 16;
  localparam int ANG_W      = 15;
  localparam int WINDOW_DEF = 10;

  // Square root datapath: 64-bit normalized radicand, 32-bit root.
  localparam int NORM_W = 64;
  localparam int ROOT_W = 32;
  localparam int REM_W  = 36;
  localparam int K_W    = 5;

  // CORDIC datapath: vector components and angle in units of 1e-7 degree.
  localparam int XY_W         = 56;
  localparam int Z_W          = 32;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = 5;

  // Rounding to hundredths of a degree: (mag + 50000) / 100000, done as a
  // shift by 5 and a multiply by the reciprocal of 3125 scaled by 2^38.
  localparam int MAG_W       = 31;
  localparam int HALF_CD     = 50000;
  localparam int PRE_SHIFT   = 5;
  localparam int MSH_W       = MAG_W - PRE_SHIFT;
  localparam int RECIP_W     = 27;
  localparam int RECIP       = 87960931;
  localparam int RECIP_SHIFT = 38;
  localparam int PROD_W      = MSH_W + RECIP_W;
  localparam int MAX_CD      = 9000;

  // Status of one angle unit as seen by the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } tilt_stat_t;

  // atan(2^-i) in units of 1e-7 degree.
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] v;
    begin
      case (i)
        5'd0:    v = 32'sd450000000;
        5'd1:    v = 32'sd265650512;
        5'd2:    v = 32'sd140362435;
        5'd3:    v = 32'sd71250163;
        5'd4:    v = 32'sd35763344;
        5'd5:    v = 32'sd17899106;
        5'd6:    v = 32'sd8951737;
        5'd7:    v = 32'sd4476142;
        5'd8:    v = 32'sd2238105;
        5'd9:    v = 32'sd1119057;
        5'd10:   v = 32'sd559529;
        5'd11:   v = 32'sd279765;
        5'd12:   v = 32'sd139882;
        5'd13:   v = 32'sd69941;
        5'd14:   v = 32'sd34971;
        5'd15:   v = 32'sd17485;
        5'd16:   v = 32'sd8743;
        5'd17:   v = 32'sd4371;
        5'd18:   v = 32'sd2186;
        5'd19:   v = 32'sd1093;
        5'd20:   v = 32'sd546;
        5'd21:   v = 32'sd273;
        5'd22:   v = 32'sd137;
        5'd23:   v = 32'sd68;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

>>> rtl/aat_tilt.sv
// Iterative atan2(a, sqrt(s)) unit: normalize, bit-serial square root, CORDIC, rounding.
// Depends on aat_pkg for widths, the arctangent table and the status struct.
module aat_tilt import aat_pkg::*; #(
  parameter int A_W = 21,
  parameter int S_W = 40
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [A_W-1:0]   a,
  input  logic [S_W-1:0]          s,
  output tilt_stat_t              stat,
  output logic signed [ANG_W-1:0] angle
);

  localparam logic [2:0] T_IDLE  = 3'd0;
  localparam logic [2:0] T_NORM  = 3'd1;
  localparam logic [2:0] T_SQRT  = 3'd2;
  localparam logic [2:0] T_LOAD  = 3'd3;
  localparam logic [2:0] T_CORD  = 3'd4;
  localparam logic [2:0] T_ROUND = 3'd5;
  localparam logic [2:0] T_FIN   = 3'd6;

  logic [2:0]              st;
  logic                    done;
  logic [NORM_W-1:0]       norm;
  logic [K_W-1:0]          kcnt;
  logic signed [A_W-1:0]   a_r;
  logic [ROOT_W-1:0]       root;
  logic [REM_W-1:0]        rem;
  logic [STEP_W-1:0]       icnt;
  logic signed [XY_W-1:0]  x;
  logic signed [XY_W-1:0]  y;
  logic signed [Z_W-1:0]   z;
  logic [PROD_W-1:0]       prod;
  logic                    neg;

  logic [REM_W-1:0]        rem_sh;
  logic [REM_W-1:0]        trial;
  logic signed [XY_W-1:0]  dx;
  logic signed [XY_W-1:0]  dy;
  logic signed [XY_W-1:0]  a_ext;
  logic [MAG_W-1:0]        mag;
  logic [MSH_W-1:0]        msh;
  logic [ANG_W-1:0]        q;
  logic [ANG_W-1:0]        qc;

  // Shift toward zero: the magnitude is shifted, never a negative value.
  function automatic logic signed [XY_W-1:0] shr_tz(input logic signed [XY_W-1:0] v,
                                                    input logic [STEP_W-1:0] sh);
    logic signed [XY_W-1:0] r;
    begin
      if (!v[XY_W-1]) begin
        r = v >> sh;
      end else begin
        r = -((-v) >> sh);
      end
      return r;
    end
  endfunction

  // One square root digit: bring in two radicand bits and try the next root bit.
  assign rem_sh = {rem[REM_W-3:0], norm[NORM_W-1 -: 2]};
  assign trial  = REM_W'({root, 2'b01});

  // CORDIC step terms and the scaled numerator.
  assign dx    = shr_tz(y, icnt);
  assign dy    = shr_tz(x, icnt);
  assign a_ext = XY_W'(a_r);

  // Rounding operands.
  assign mag = z[Z_W-1] ? MAG_W'(-z) : MAG_W'(z);
  assign msh = MSH_W'((mag + MAG_W'(HALF_CD)) >> PRE_SHIFT);
  assign q   = prod[RECIP_SHIFT +: ANG_W];
  assign qc  = (q > ANG_W'(MAX_CD)) ? ANG_W'(MAX_CD) : q;

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= T_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        T_IDLE: begin
          if (start) begin
            if (s == '0) begin
              done <= 1'b1;
            end else begin
              st <= T_NORM;
            end
          end
        end
        T_NORM: begin
          if (norm[NORM_W-1 -: 3] != '0) begin
            st <= T_SQRT;
          end
        end
        T_SQRT: begin
          if (icnt == STEP_W'(ROOT_W - 1)) begin
            st <= T_LOAD;
          end
        end
        T_LOAD:  st <= T_CORD;
        T_CORD: begin
          if (icnt == STEP_W'(CORDIC_STEPS - 1)) begin
            st <= T_ROUND;
          end
        end
        T_ROUND: st <= T_FIN;
        T_FIN: begin
          st   <= T_IDLE;
          done <= 1'b1;
        end
        default: st <= T_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (st)
      T_IDLE: begin
        if (start) begin
          a_r  <= a;
          norm <= NORM_W'(s);
          kcnt <= '0;
          if (a > 0) begin
            angle <= ANG_W'(MAX_CD);
          end else if (a < 0) begin
            angle <= -ANG_W'(MAX_CD);
          end else begin
            angle <= '0;
          end
        end
      end
      T_NORM: begin
        // Shift by pairs of bits until the top set bit reaches bit 61 or 62.
        if (norm[NORM_W-1 -: 11] == '0) begin
          norm <= norm << 8;
          kcnt <= kcnt + K_W'(4);
        end else if (norm[NORM_W-1 -: 3] == '0) begin
          norm <= norm << 2;
          kcnt <= kcnt + K_W'(1);
        end else begin
          root <= '0;
          rem  <= '0;
          icnt <= '0;
        end
      end
      T_SQRT: begin
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        norm <= norm << 2;
        icnt <= icnt + STEP_W'(1);
      end
      T_LOAD: begin
        x    <= XY_W'(root);
        y    <= a_ext <<< kcnt;
        z    <= '0;
        icnt <= '0;
      end
      T_CORD: begin
        // Rotate toward the x axis and accumulate the angle.
        if (y > 0) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + atan_entry(icnt);
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - atan_entry(icnt);
        end
        icnt <= icnt + STEP_W'(1);
      end
      T_ROUND: begin
        prod <= PROD_W'(msh) * PROD_W'(RECIP);
        neg  <= z[Z_W-1];
      end
      T_FIN: begin
        angle <= neg ? -$signed(qc) : $signed(qc);
      end
      default: ;
    endcase
  end

  assign stat.busy = (st != T_IDLE);
  assign stat.done = done;

endmodule

>>> rtl/averaged_accel_tilt_angles.sv
// An input transfer updates the running sums, squares each axis sum and starts both angle
// units (normalize, bit-serial square root, CORDIC); the result is loaded when both are done.
// A new item is taken only once the last result is loaded; the ring is read and written once per item.
// Reset clears the ring valid bits, the write position and the axis sums at once;
// an entry never written reads as zero, so no clearing pass is needed.
// Depends on aat_pkg and aat_tilt.
module averaged_accel_tilt_angles import aat_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [DATA_W-1:0] accel_x,
  input  logic signed [DATA_W-1:0] accel_y,
  input  logic signed [DATA_W-1:0] accel_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ANG_W-1:0] pitch_centideg,
  output logic signed [ANG_W-1:0] roll_centideg
);

  localparam int SUM_W = DATA_W + $clog2(WINDOW);
  localparam int SQ_W  = 2 * SUM_W;
  localparam int A_W   = SUM_W + 1;
  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int ENT_W = 3 * DATA_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_SQX  = 3'd2;
  localparam logic [2:0] S_SQY  = 3'd3;
  localparam logic [2:0] S_SQZ  = 3'd4;
  localparam logic [2:0] S_TILT = 3'd5;
  localparam logic [2:0] S_WAIT = 3'd6;

  logic [2:0]               state;
  logic [PTR_W-1:0]         wpos;
  logic [WINDOW-1:0]        vld;
  logic [ENT_W-1:0]         ring [WINDOW];
  logic [ENT_W-1:0]         rd_data;
  logic                     rd_vld;
  logic signed [DATA_W-1:0] in_x;
  logic signed [DATA_W-1:0] in_y;
  logic signed [DATA_W-1:0] in_z;
  logic signed [SUM_W-1:0]  sum_x;
  logic signed [SUM_W-1:0]  sum_y;
  logic signed [SUM_W-1:0]  sum_z;
  logic [SQ_W-2:0]          sq_x;
  logic [SQ_W-2:0]          sq_y;
  logic [SQ_W-2:0]          sq_z;
  logic                     pdone;
  logic                     rdone;

  logic                     in_xfer;
  logic                     res_load;
  logic [ENT_W-1:0]         old;
  logic signed [SUM_W-1:0]  mul_op;
  logic signed [SQ_W-1:0]   mul_res;
  logic                     tilt_start;
  logic [SQ_W-1:0]          s_pitch;
  logic [SQ_W-1:0]          s_roll;
  logic signed [A_W-1:0]    a_pitch;
  logic signed [A_W-1:0]    a_roll;
  tilt_stat_t               pstat;
  tilt_stat_t               rstat;
  logic signed [ANG_W-1:0]  p_angle;
  logic signed [ANG_W-1:0]  r_angle;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // Both angles are ready and the output register is free or being emptied.
  assign res_load = (state == S_WAIT) && pdone && rdone && (!out_valid || out_ready);

  // Oldest sample leaving the window; an entry never written counts as zero.
  assign old = rd_vld ? rd_data : '0;

  // One shared squarer, used for one axis per cycle.
  always_comb begin
    case (state)
      S_SQX:   mul_op = sum_x;
      S_SQY:   mul_op = sum_y;
      default: mul_op = sum_z;
    endcase
  end
  assign mul_res = mul_op * mul_op;

  // Operands of the two angle units.
  assign tilt_start = (state == S_TILT);
  assign s_pitch    = {1'b0, sq_x} + {1'b0, sq_z};
  assign s_roll     = {1'b0, sq_y} + {1'b0, sq_z};
  assign a_pitch    = A_W'(sum_y);
  assign a_roll     = -A_W'(sum_x);

  // Sample ring memory: one registered read and one write per item.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_data <= ring[wpos];
    end
    if (state == S_UPD) begin
      ring[wpos] <= {in_x, in_y, in_z};
    end
  end

  // Input capture and squares.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_x <= accel_x;
      in_y <= accel_y;
      in_z <= accel_z;
    end
    case (state)
      S_SQX:   sq_x <= mul_res[SQ_W-2:0];
      S_SQY:   sq_y <= mul_res[SQ_W-2:0];
      S_SQZ:   sq_z <= mul_res[SQ_W-2:0];
      default: ;
    endcase
  end

  // Sequencer, ring bookkeeping, running sums and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wpos      <= '0;
      vld       <= '0;
      rd_vld    <= 1'b0;
      sum_x     <= '0;
      sum_y     <= '0;
      sum_z     <= '0;
      pdone     <= 1'b0;
      rdone     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            rd_vld <= vld[wpos];
            state  <= S_UPD;
          end
        end
        S_UPD: begin
          sum_x <= sum_x + SUM_W'(in_x) - SUM_W'($signed(old[3*DATA_W-1 -: DATA_W]));
          sum_y <= sum_y + SUM_W'(in_y) - SUM_W'($signed(old[2*DATA_W-1 -: DATA_W]));
          sum_z <= sum_z + SUM_W'(in_z) - SUM_W'($signed(old[DATA_W-1:0]));
          vld[wpos] <= 1'b1;
          wpos  <= (wpos == PTR_W'(WINDOW - 1)) ? '0 : wpos + PTR_W'(1);
          state <= S_SQX;
        end
        S_SQX: state <= S_SQY;
        S_SQY: state <= S_SQZ;
        S_SQZ: state <= S_TILT;
        S_TILT: begin
          pdone <= 1'b0;
          rdone <= 1'b0;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (pstat.done) begin
            pdone <= 1'b1;
          end
          if (rstat.done) begin
            rdone <= 1'b1;
          end
          if (res_load) begin
            pitch_centideg <= -p_angle;
            roll_centideg  <= -r_angle;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Pitch and roll run side by side.
  aat_tilt #(.A_W(A_W), .S_W(SQ_W)) u_pitch (
    .clk   (clk),
    .rst   (rst),
    .start (tilt_start),
    .a     (a_pitch),
    .s     (s_pitch),
    .stat  (pstat),
    .angle (p_angle)
  );

  aat_tilt #(.A_W(A_W), .S_W(SQ_W)) u_roll (
    .clk   (clk),
    .rst   (rst),
    .start (tilt_start),
    .a     (a_roll),
    .s     (s_roll),
    .stat  (rstat),
    .angle (r_angle)
  );

`ifndef SYNTHESIS
  // The write position always points inside the ring.
  a_wpos_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, wpos} < (PTR_W + 1)'(WINDOW))
    else $error("write position outside the ring");

  // Both angle units are quiet whenever a new transfer can be taken.
  a_idle_units: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!pstat.busy && !rstat.busy))
    else $error("angle unit busy while block idle");

  // A result appears only at the end of the wait for both units.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_WAIT && pdone && rdone))
    else $error("result raised without both angles");

  // Delivered angles stay within plus or minus ninety degrees.
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pitch_centideg <= 15'sd9000 && pitch_centideg >= -15'sd9000 &&
                   roll_centideg <= 15'sd9000 && roll_centideg >= -15'sd9000))
    else $error("angle out of range");
`endif

endmodule
